// ===== src/icl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icl_pkg: shared types and codes for the indexed character list
// Opcodes, status codes and the per-cell update command.
// ----------------------------------------------------------------------------

package icl_pkg;

	// request opcodes
	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_READ   = 3'd3,
		OP_CLEAR  = 3'd4
	} opcode_t;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// field widths fixed by the interface
	localparam int ELEM_W   = 8;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	// update command broadcast to every cell, already checked for range and room
	typedef struct packed {
		logic app;
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

// ===== src/icl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icl_cell: one slot of the list
// Holds one byte and takes the new word, its left or right neighbor, or keeps
// its own, depending on where it sits relative to the position and the count.
// ----------------------------------------------------------------------------

module icl_cell #(
	parameter int IDX = 0,
	parameter int PW  = 5
) (
	input  logic                            clk,
	input  icl_pkg::cell_cmd_t              cmd,
	input  logic [PW-1:0]                   pos,
	input  logic [PW-1:0]                   cnt,
	input  logic [icl_pkg::ELEM_W-1:0]      element,
	input  logic [icl_pkg::ELEM_W-1:0]      left,
	input  logic [icl_pkg::ELEM_W-1:0]      right,
	output logic [icl_pkg::ELEM_W-1:0]      data,
	output logic [icl_pkg::ELEM_W-1:0]      rd
);

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic [icl_pkg::ELEM_W-1:0] data_q;
	logic [icl_pkg::ELEM_W-1:0] data_d;
	logic [PW:0]                idx_plus1;

	assign idx_plus1 = {1'b0, MY_IDX} + 1'b1;

	// next value of this slot
	always_comb begin
		data_d = data_q;
		if (cmd.app && (MY_IDX == cnt)) begin
			data_d = element;
		end else if (cmd.ins) begin
			if (MY_IDX == pos) begin
				data_d = element;
			end else if ((MY_IDX > pos) && (MY_IDX <= cnt)) begin
				data_d = left;
			end
		end else if (cmd.del) begin
			if ((MY_IDX >= pos) && (idx_plus1 < {1'b0, cnt})) begin
				data_d = right;
			end
		end
	end

	// slot storage, undefined until written
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

	// read tap, zero unless this slot is addressed
	assign rd = (MY_IDX == pos) ? data_q : '0;

endmodule

// ===== src/indexed_char_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_char_list_unit: ordered byte list with positional insert and delete
// Append, insert, delete, read and clear on a list of up to CAPACITY bytes.
// ----------------------------------------------------------------------------

// One request is taken in every cycle: busy stays low, and the result word
// appears on read_value, status and count in the cycle after start, marked by
// done for exactly that cycle. The list lives in a row of CAPACITY cells; those
// from the addressed position to the end of the list shift toward or away from
// it at the same clock edge, so an insert or delete takes no longer than any other request. The
// result cannot be stalled; it must be taken in the cycle that done is high.

module indexed_char_list_unit #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          opcode,
	input  logic [icl_pkg::ELEM_W-1:0]          element,
	input  logic [icl_pkg::POS_W-1:0]           position,
	output logic                                done,
	output logic [icl_pkg::ELEM_W-1:0]          read_value,
	output logic [icl_pkg::STATUS_W-1:0]        status,
	output logic [icl_pkg::COUNT_W-1:0]         count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > icl_pkg::POS_W) ? CW : icl_pkg::POS_W;

	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 cnt_d;
	logic [PW-1:0]                 cnt_x;
	logic [PW-1:0]                 pos_x;
	logic                          full;
	icl_pkg::cell_cmd_t            cmd;
	logic [icl_pkg::STATUS_W-1:0]  st_d;
	logic [icl_pkg::ELEM_W-1:0]    val_d;
	logic [icl_pkg::ELEM_W-1:0]    rd_or;
	logic [icl_pkg::ELEM_W-1:0]    cell_data [CAPACITY];
	logic [icl_pkg::ELEM_W-1:0]    cell_rd   [CAPACITY];
	logic                          done_q;
	logic [icl_pkg::ELEM_W-1:0]    val_q;
	logic [icl_pkg::STATUS_W-1:0]  st_q;
	logic [PW-1:0]                 cnt_out_x;

	assign busy  = 1'b0;
	assign cnt_x = PW'(cnt_q);
	assign pos_x = PW'(position);
	assign full  = (cnt_q == CW'(CAPACITY));

	// merge the read taps of all cells
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	// decode the request and check range and room
	always_comb begin
		cmd   = '0;
		st_d  = icl_pkg::ST_OK;
		val_d = '0;
		cnt_d = cnt_q;
		case (icl_pkg::opcode_t'(opcode))
			icl_pkg::OP_APPEND: begin
				if (full) begin
					st_d = icl_pkg::ST_FULL;
				end else begin
					cmd.app = start;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			icl_pkg::OP_INSERT: begin
				if (pos_x > cnt_x) begin
					st_d = icl_pkg::ST_RANGE;
				end else if (full) begin
					st_d = icl_pkg::ST_FULL;
				end else begin
					cmd.ins = start;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			icl_pkg::OP_DELETE: begin
				if (pos_x >= cnt_x) begin
					st_d = icl_pkg::ST_RANGE;
				end else begin
					cmd.del = start;
					cnt_d   = cnt_q - 1'b1;
				end
			end
			icl_pkg::OP_READ: begin
				if (pos_x >= cnt_x) begin
					st_d = icl_pkg::ST_RANGE;
				end else begin
					val_d = rd_or;
				end
			end
			icl_pkg::OP_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
	end

	// row of cells, each linked to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [icl_pkg::ELEM_W-1:0] left_w;
		logic [icl_pkg::ELEM_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		icl_cell #(
			.IDX (i),
			.PW  (PW)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.pos     (pos_x),
			.cnt     (cnt_x),
			.element (element),
			.left    (left_w),
			.right   (right_w),
			.data    (cell_data[i]),
			.rd      (cell_rd[i])
		);
	end

	// count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start) begin
				cnt_q <= cnt_d;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= val_d;
			st_q  <= st_d;
		end
	end

	assign cnt_out_x  = PW'(cnt_q);
	assign done       = done_q;
	assign read_value = val_q;
	assign status     = st_q;
	assign count      = cnt_out_x[icl_pkg::COUNT_W-1:0];

`ifndef SYNTH
	// count never passes the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("count above capacity");

	// a successful append grows the list by one
	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (opcode == icl_pkg::OP_APPEND) && !full)
		|=> (done && (cnt_q == CW'($past(cnt_q) + 1'b1))))
		else $error("append did not grow the list");

	// a failed request leaves the count alone
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (st_q != icl_pkg::ST_OK)) |-> (cnt_q == $past(cnt_q)))
		else $error("failed request changed the count");

	// a nonzero read word only comes with ok status
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (val_q != '0)) |-> (st_q == icl_pkg::ST_OK))
		else $error("read value with error status");

	// the count moves only after an accepted request
	a_cnt_still: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> $stable(cnt_q))
		else $error("count moved without a request");
`endif

endmodule
